@@ sv/mlqs_pkg.sv @@
`timescale 1ns / 1ps
package mlqs_pkg;

  // task classes
  localparam logic [1:0] CLS_HIGH = 2'd0;
  localparam logic [1:0] CLS_MID  = 2'd1;
  localparam logic [1:0] CLS_LOW  = 2'd2;

  // result kinds
  localparam logic [1:0] RK_ADMIT_OK  = 2'd0;
  localparam logic [1:0] RK_ADMIT_REJ = 2'd1;
  localparam logic [1:0] RK_SERVED    = 2'd2;
  localparam logic [1:0] RK_IDLE      = 2'd3;

  // request types
  localparam logic REQ_ADMIT = 1'b0;

  // configuration register indexes
  localparam logic [2:0] CFG_BUDGET_HIGH = 3'd0;
  localparam logic [2:0] CFG_BUDGET_MID  = 3'd1;
  localparam logic [2:0] CFG_BUDGET_LOW  = 3'd2;
  localparam logic [2:0] CFG_QUANTUM     = 3'd3;
  localparam logic [2:0] CFG_THRESH_HIGH = 3'd4;
  localparam logic [2:0] CFG_THRESH_MID  = 3'd5;

  // list operations, at most one per cycle
  typedef struct packed {
    logic push;
    logic pop;
    logic drop;
  } lop_t;

endpackage

@@ sv/multilevel_queue_tick_scheduler.sv @@
`timescale 1ns / 1ps
// multilevel queue tick scheduler
// start with in_req_type low admits a task (id, score, burst); high is one
// time tick. a word is taken when start is high and busy is low.
// every word gives exactly one result word on the out_ ports, marked by
// out_strobe for one cycle; the receiver cannot stall it.
// an admit's result is registered and appears in the cycle after it is taken, and busy never rises.
// a tick walks a small sequencer: requeue, phase skipping, for the
// shortest-first class one step per listed task through a single shared
// compare unit, slice setup, then service.
// cfg_we writes register cfg_index from cfg_wdata; write only
// while idle. unknown indexes are ignored.
// synchronous reset restores register defaults, empties all queues and
// marks no task active; task storage needs no clearing pass.
module multilevel_queue_tick_scheduler #(
  parameter int MAX_TASKS   = 16,
  parameter int BURST_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [3:0]  in_task_id,
  input  logic [7:0]  in_priority_score,
  input  logic [15:0] in_burst_length,
  output logic        out_strobe,
  output logic [1:0]  out_result_kind,
  output logic [3:0]  out_served_task,
  output logic [1:0]  out_served_class,
  output logic        out_first_service,
  output logic        out_task_done,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import mlqs_pkg::*;

  localparam int IDW = (MAX_TASKS > 2) ? $clog2(MAX_TASKS) : 1;
  localparam int CW  = $clog2(MAX_TASKS + 1);
  localparam int BW  = BURST_WIDTH;
  localparam logic [32:0] BMAX = (33'd1 << BW) - 33'd1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SEL   = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_SLICE = 3'd4;
  localparam logic [2:0] S_SERVE = 3'd5;

  logic [2:0]     state_r;
  logic [7:0]     bud_high_r, bud_mid_r, bud_low_r, quantum_r, thr_high_r, thr_mid_r;
  logic [1:0]     phase_r;
  logic [7:0]     phase_used_r, slice_left_r;
  logic           svc_valid_r, requeue_r, round_served_r;
  logic [IDW-1:0] svc_id_r, svc_pos_r, cand_id_r, cand_pos_r, best_pos_r, best_id_r;
  logic [7:0]     cand_s_r;
  logic [BW-1:0]  best_val_r;
  logic [CW-1:0]  scan_k_r, active_n_r;
  logic           active_r  [MAX_TASKS];
  logic           started_r [MAX_TASKS];
  logic [BW-1:0]  rem_r     [MAX_TASKS];
  logic [1:0]     cls_r     [MAX_TASKS];

  logic [IDW-1:0] hi_head, lo_head, mid_rd, unused_hi_rd, unused_lo_rd, unused_mid_head;
  logic [CW-1:0]  hi_n, mid_n, lo_n;
  lop_t           hi_op, mid_op, lo_op;
  logic [IDW-1:0] hi_push_id;

  assign busy = (state_r != S_IDLE);

  // admit decode
  logic           admit_go, admit_ok;
  logic [IDW-1:0] in_idx;
  logic [1:0]     in_cls;
  logic [BW-1:0]  in_burst;
  assign admit_go = start && !busy && (in_req_type == REQ_ADMIT);
  assign in_idx   = IDW'(in_task_id);
  assign admit_ok = (in_burst_length != '0) && (32'(in_task_id) < 32'(MAX_TASKS)) &&
                    !active_r[in_idx] && (32'(active_n_r) < 32'(MAX_TASKS));
  assign in_cls   = (in_priority_score <= thr_high_r) ? CLS_HIGH :
                    (in_priority_score <= thr_mid_r) ? CLS_MID : CLS_LOW;
  assign in_burst = (33'(in_burst_length) > BMAX) ? BW'(BMAX) : BW'(in_burst_length);

  // shared remaining-ticks read port
  logic [IDW-1:0] rem_idx;
  logic [BW-1:0]  rem_rd;
  always_comb begin
    unique case (state_r)
      S_SCAN:  rem_idx = mid_rd;
      S_SLICE: rem_idx = cand_id_r;
      default: rem_idx = svc_id_r;
    endcase
  end
  assign rem_rd = rem_r[rem_idx];

  // phase budget and occupancy
  logic [7:0]    bud, left, qnt;
  logic [CW-1:0] cnt;
  logic          skip;
  always_comb begin
    unique case (phase_r)
      CLS_HIGH: begin bud = bud_high_r; cnt = hi_n; end
      CLS_MID:  begin bud = bud_mid_r;  cnt = mid_n; end
      default:  begin bud = bud_low_r;  cnt = lo_n; end
    endcase
    skip = (phase_used_r >= bud) || (cnt == '0);
    left = bud - phase_used_r;
    qnt  = (quantum_r == '0) ? 8'd1 : quantum_r;
  end

  // service step values
  logic [BW-1:0] new_rem;
  logic          svc_done;
  logic [1:0]    svc_cls;
  logic [7:0]    slice_dec;
  assign new_rem   = (rem_rd != '0) ? rem_rd - 1'b1 : '0;
  assign svc_done  = (new_rem == '0);
  assign svc_cls   = cls_r[svc_id_r];
  assign slice_dec = slice_left_r - 8'd1;

  // slice length clamp
  logic [7:0] slice_s;
  always_comb begin
    slice_s = (32'(rem_rd) < 32'(cand_s_r)) ? 8'(rem_rd) : cand_s_r;
    if (slice_s == '0) slice_s = 8'd1;
  end

  // list operations
  logic requeue_go;
  assign requeue_go = (state_r == S_SEL) && !(svc_valid_r && slice_left_r != '0) &&
                      requeue_r && (32'(hi_n) < 32'(MAX_TASKS));
  always_comb begin
    hi_op  = '0;
    mid_op = '0;
    lo_op  = '0;
    hi_push_id = requeue_go ? svc_id_r : in_idx;
    hi_op.push  = (admit_go && admit_ok && in_cls == CLS_HIGH) || requeue_go;
    mid_op.push = admit_go && admit_ok && in_cls == CLS_MID;
    lo_op.push  = admit_go && admit_ok && in_cls == CLS_LOW;
    hi_op.pop   = (state_r == S_PICK) && !skip && (phase_r == CLS_HIGH);
    lo_op.drop  = (state_r == S_SERVE) && svc_done && svc_cls == CLS_LOW;
    mid_op.drop = (state_r == S_SERVE) && svc_done && svc_cls == CLS_MID;
  end

  mlqs_list #(.DEPTH(MAX_TASKS), .IDW(IDW), .CW(CW)) u_high (
    .clk, .rst_n, .op(hi_op), .push_id(hi_push_id), .drop_pos(svc_pos_r),
    .rd_idx('0), .head(hi_head), .rd_data(unused_hi_rd), .count(hi_n)
  );
  mlqs_list #(.DEPTH(MAX_TASKS), .IDW(IDW), .CW(CW)) u_mid (
    .clk, .rst_n, .op(mid_op), .push_id(in_idx), .drop_pos(svc_pos_r),
    .rd_idx(scan_k_r[IDW-1:0]), .head(unused_mid_head), .rd_data(mid_rd), .count(mid_n)
  );
  mlqs_list #(.DEPTH(MAX_TASKS), .IDW(IDW), .CW(CW)) u_low (
    .clk, .rst_n, .op(lo_op), .push_id(in_idx), .drop_pos(svc_pos_r),
    .rd_idx('0), .head(lo_head), .rd_data(unused_lo_rd), .count(lo_n)
  );

  // task storage, no reset
  always_ff @(posedge clk) begin
    if (admit_go && admit_ok) begin
      rem_r[in_idx] <= in_burst;
      cls_r[in_idx] <= in_cls;
    end else if (state_r == S_SERVE) begin
      rem_r[svc_id_r] <= new_rem;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bud_high_r <= 8'd5;
      bud_mid_r  <= 8'd3;
      bud_low_r  <= 8'd2;
      quantum_r  <= 8'd2;
      thr_high_r <= 8'd10;
      thr_mid_r  <= 8'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BUDGET_HIGH: bud_high_r <= cfg_wdata;
        CFG_BUDGET_MID:  bud_mid_r  <= cfg_wdata;
        CFG_BUDGET_LOW:  bud_low_r  <= cfg_wdata;
        CFG_QUANTUM:     quantum_r  <= cfg_wdata;
        CFG_THRESH_HIGH: thr_high_r <= cfg_wdata;
        CFG_THRESH_MID:  thr_mid_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      phase_r        <= CLS_HIGH;
      phase_used_r   <= '0;
      slice_left_r   <= '0;
      svc_valid_r    <= 1'b0;
      requeue_r      <= 1'b0;
      round_served_r <= 1'b0;
      active_n_r     <= '0;
      out_strobe     <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        active_r[i]  <= 1'b0;
        started_r[i] <= 1'b0;
      end
    end else begin
      out_strobe <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_req_type == REQ_ADMIT) begin
              out_strobe        <= 1'b1;
              out_result_kind   <= admit_ok ? RK_ADMIT_OK : RK_ADMIT_REJ;
              out_served_task   <= '0;
              out_served_class  <= '0;
              out_first_service <= 1'b0;
              out_task_done     <= 1'b0;
              if (admit_ok) begin
                active_r[in_idx]  <= 1'b1;
                started_r[in_idx] <= 1'b0;
                active_n_r        <= active_n_r + 1'b1;
              end
            end else begin
              state_r <= S_SEL;
            end
          end
        end
        S_SEL: begin
          if (svc_valid_r && slice_left_r != '0) begin
            state_r <= S_SERVE;
          end else begin
            if (requeue_r) begin
              requeue_r   <= 1'b0;
              svc_valid_r <= 1'b0;
            end
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          if (skip) begin
            phase_used_r <= '0;
            if (phase_r != CLS_LOW) begin
              phase_r <= phase_r + 2'd1;
            end else begin
              phase_r <= CLS_HIGH;
              if (!round_served_r) begin
                out_strobe        <= 1'b1;
                out_result_kind   <= RK_IDLE;
                out_served_task   <= '0;
                out_served_class  <= '0;
                out_first_service <= 1'b0;
                out_task_done     <= 1'b0;
                state_r           <= S_IDLE;
              end else begin
                round_served_r <= 1'b0;
              end
            end
          end else begin
            unique case (phase_r)
              CLS_HIGH: begin
                cand_id_r  <= hi_head;
                cand_pos_r <= '0;
                cand_s_r   <= (left < qnt) ? left : qnt;
                state_r    <= S_SLICE;
              end
              CLS_MID: begin
                best_pos_r <= '0;
                best_id_r  <= '0;
                best_val_r <= '1;
                scan_k_r   <= '0;
                state_r    <= S_SCAN;
              end
              default: begin
                cand_id_r  <= lo_head;
                cand_pos_r <= '0;
                cand_s_r   <= left;
                state_r    <= S_SLICE;
              end
            endcase
          end
        end
        S_SCAN: begin
          // one list entry per cycle through the compare unit
          if (scan_k_r < mid_n) begin
            if (scan_k_r == '0 || rem_rd < best_val_r) begin
              best_val_r <= rem_rd;
              best_pos_r <= scan_k_r[IDW-1:0];
              best_id_r  <= mid_rd;
            end
            scan_k_r <= scan_k_r + 1'b1;
          end else begin
            cand_id_r  <= best_id_r;
            cand_pos_r <= best_pos_r;
            cand_s_r   <= left;
            state_r    <= S_SLICE;
          end
        end
        S_SLICE: begin
          svc_id_r     <= cand_id_r;
          svc_pos_r    <= cand_pos_r;
          svc_valid_r  <= 1'b1;
          slice_left_r <= slice_s;
          state_r      <= S_SERVE;
        end
        default: begin
          // serve one tick
          out_strobe          <= 1'b1;
          out_result_kind     <= RK_SERVED;
          out_served_task     <= 4'(svc_id_r);
          out_served_class    <= svc_cls;
          out_first_service   <= !started_r[svc_id_r];
          out_task_done       <= svc_done;
          started_r[svc_id_r] <= 1'b1;
          phase_used_r        <= phase_used_r + 8'd1;
          round_served_r      <= 1'b1;
          state_r             <= S_IDLE;
          if (svc_done) begin
            active_r[svc_id_r] <= 1'b0;
            if (active_n_r != '0) active_n_r <= active_n_r - 1'b1;
            svc_valid_r  <= 1'b0;
            slice_left_r <= '0;
          end else begin
            slice_left_r <= slice_dec;
            if (slice_dec == '0) begin
              if (svc_cls == CLS_HIGH) requeue_r <= 1'b1;
              else svc_valid_r <= 1'b0;
            end
          end
        end
      endcase
    end
  end

endmodule

@@ sv/mlqs_list.sv @@
`timescale 1ns / 1ps
module mlqs_list #(
  parameter int DEPTH = 16,
  parameter int IDW   = 4,
  parameter int CW    = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mlqs_pkg::lop_t    op,
  input  logic [IDW-1:0]    push_id,
  input  logic [IDW-1:0]    drop_pos,
  input  logic [IDW-1:0]    rd_idx,
  output logic [IDW-1:0]    head,
  output logic [IDW-1:0]    rd_data,
  output logic [CW-1:0]     count
);
  import mlqs_pkg::*;

  logic [IDW-1:0] ent_r [DEPTH];
  logic [CW-1:0]  count_r;

  assign head    = ent_r[0];
  assign rd_data = ent_r[rd_idx];
  assign count   = count_r;

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (op.push) begin
      count_r <= count_r + 1'b1;
    end else if (op.pop || op.drop) begin
      count_r <= count_r - 1'b1;
    end
  end

  // entries: append at tail, take from head, or close a gap
  always_ff @(posedge clk) begin
    if (op.push) begin
      ent_r[count_r[IDW-1:0]] <= push_id;
    end else if (op.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) ent_r[i] <= ent_r[i+1];
    end else if (op.drop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (IDW'(i) >= drop_pos) ent_r[i] <= ent_r[i+1];
      end
    end
  end

endmodule
